// ===== rtl/terrain_grid_skirt_index_gen_core_macros.svh =====
// Assertion macros used by the terrain index generator top level.
// Needs a clock named i_clk and an active-low reset named i_rst_n in the including module.
`ifndef TERRAIN_GRID_SKIRT_INDEX_GEN_CORE_MACROS_SVH
`define TERRAIN_GRID_SKIRT_INDEX_GEN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TGSI_ASSERT_NOW(label, cond, consequent, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (consequent)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGSI_ASSERT_NEXT(label, cond, consequent, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (consequent)) else $error(msg);

`endif

// ===== rtl/tgsi_pkg.sv =====
// Shared constants and types for the terrain grid/skirt triangle index generator.
// No dependencies; used by tgsi_index_calc and the core top level.
`default_nettype none

package tgsi_pkg;

    localparam int TRI_W            = 16;  // triangle number width
    localparam int VTX_W            = 15;  // vertex index width
    localparam int EXP_W            = 3;   // subdivision exponent width
    localparam int CNT_W            = 8;   // cells per side, up to 2^7
    localparam int MAX_EXPONENT_DEF = 7;

    localparam logic [EXP_W-1:0] EXP_RESET = 3'd1;

    // Skirt side codes, in the order the triangles are numbered.
    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
        logic             valid_res;
    } t_tri_res;

endpackage

`default_nettype wire

// ===== rtl/tgsi_index_calc.sv =====
// Combinational mapping from triangle number to three vertex indices.
// Depends on tgsi_pkg for widths, side codes and the result struct.
`default_nettype none

module tgsi_index_calc #(
    parameter int MAX_EXPONENT = tgsi_pkg::MAX_EXPONENT_DEF
) (
    input  wire logic [tgsi_pkg::EXP_W-1:0] i_exponent,
    input  wire logic [tgsi_pkg::TRI_W-1:0] i_triangle_number,
    output tgsi_pkg::t_tri_res              o_res
);

    localparam logic [tgsi_pkg::EXP_W-1:0] MAX_K = tgsi_pkg::EXP_W'(MAX_EXPONENT);

    logic [tgsi_pkg::EXP_W-1:0] k;
    logic [tgsi_pkg::CNT_W-1:0] m;
    logic [tgsi_pkg::CNT_W-1:0] mask;
    logic [tgsi_pkg::CNT_W-1:0] step;
    logic [tgsi_pkg::TRI_W:0]   grid;
    logic [tgsi_pkg::TRI_W:0]   total;
    logic [tgsi_pkg::TRI_W-1:0] s;
    logic [tgsi_pkg::VTX_W-1:0] cell_idx;
    logic [tgsi_pkg::VTX_W-1:0] row;
    logic [tgsi_pkg::VTX_W-1:0] col;
    logic [tgsi_pkg::VTX_W-1:0] a;
    logic [tgsi_pkg::VTX_W-1:0] mw;
    logic [tgsi_pkg::VTX_W-1:0] stepw;
    logic [tgsi_pkg::VTX_W-1:0] nn;
    logic [tgsi_pkg::VTX_W-1:0] d;
    logic [tgsi_pkg::VTX_W-1:0] s0;
    logic [tgsi_pkg::VTX_W-1:0] s1;
    logic [tgsi_pkg::VTX_W-1:0] e0;
    logic [tgsi_pkg::VTX_W-1:0] e1;
    logic [1:0]                 side;
    logic                       in_range;
    logic                       is_grid;

    always_comb begin
        if (i_exponent > MAX_K) begin
            k = MAX_K;
        end else begin
            k = i_exponent;
        end

        // Patch geometry: m cells per side, n = m + 1 vertices per side.
        m     = tgsi_pkg::CNT_W'(1) << k;
        mask  = m - tgsi_pkg::CNT_W'(1);
        mw    = tgsi_pkg::VTX_W'(m);
        grid  = (tgsi_pkg::TRI_W + 1)'(1) << (4'({1'b0, k} << 1) + 4'd1);
        total = grid + (tgsi_pkg::TRI_W + 1)'({m, 3'b000});

        in_range = (k != '0) && ({1'b0, i_triangle_number} < total);
        is_grid  = {1'b0, i_triangle_number} < grid;

        // Grid cell base a = row * n + col, with the multiply as shift and add.
        cell_idx = i_triangle_number[tgsi_pkg::TRI_W-1:1];
        row      = cell_idx >> k;
        col      = tgsi_pkg::VTX_W'(cell_idx[tgsi_pkg::CNT_W-1:0] & mask);
        a        = tgsi_pkg::VTX_W'(row << k) + row + col;

        // Skirt: n*n is the first skirt vertex.
        nn    = tgsi_pkg::VTX_W'(tgsi_pkg::VTX_W'(1) << {k, 1'b0})
              + tgsi_pkg::VTX_W'({m, 1'b0}) + tgsi_pkg::VTX_W'(1);
        s     = tgsi_pkg::TRI_W'(i_triangle_number - grid[tgsi_pkg::TRI_W-1:0]);
        side  = 2'(s >> ({1'b0, k} + 4'd1));
        step  = s[tgsi_pkg::CNT_W:1] & mask;
        stepw = tgsi_pkg::VTX_W'(step);
        s0    = nn + tgsi_pkg::VTX_W'(tgsi_pkg::VTX_W'(side) << k) + stepw;
        s1    = s0 + tgsi_pkg::VTX_W'(1);
        d     = mw - stepw;

        unique case (side)
            tgsi_pkg::SIDE_TOP: begin
                e0 = stepw;
                e1 = stepw + tgsi_pkg::VTX_W'(1);
            end
            tgsi_pkg::SIDE_RIGHT: begin
                e0 = tgsi_pkg::VTX_W'(stepw << k) + stepw + mw;
                e1 = e0 + mw + tgsi_pkg::VTX_W'(1);
            end
            tgsi_pkg::SIDE_BOTTOM: begin
                e0 = tgsi_pkg::VTX_W'(mw << k) + mw + mw - stepw;
                e1 = e0 - tgsi_pkg::VTX_W'(1);
            end
            tgsi_pkg::SIDE_LEFT: begin
                e0 = tgsi_pkg::VTX_W'(d << k) + d;
                e1 = e0 - mw - tgsi_pkg::VTX_W'(1);
                // The final left-side step closes the ring on the first skirt vertex.
                if (step == mask) begin
                    s1 = nn;
                end
            end
        endcase

        if (!in_range) begin
            o_res = '0;
        end else if (is_grid) begin
            o_res.valid_res = 1'b1;
            o_res.vertex_a  = a;
            if (!i_triangle_number[0]) begin
                o_res.vertex_b = a + tgsi_pkg::VTX_W'(1);
                o_res.vertex_c = a + mw + tgsi_pkg::VTX_W'(2);
            end else begin
                o_res.vertex_b = a + mw + tgsi_pkg::VTX_W'(2);
                o_res.vertex_c = a + mw + tgsi_pkg::VTX_W'(1);
            end
        end else begin
            o_res.valid_res = 1'b1;
            o_res.vertex_b  = s0;
            if (!s[0]) begin
                o_res.vertex_a = e0;
                o_res.vertex_c = e1;
            end else begin
                o_res.vertex_a = e1;
                o_res.vertex_c = s1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/terrain_grid_skirt_index_gen_core.sv =====
// Top level of the terrain patch triangle index generator with skirt.
// Depends on tgsi_pkg, tgsi_index_calc and terrain_grid_skirt_index_gen_core_macros.svh.
//
// Usage:
// The input channel (i_tri_valid / o_tri_ready) carries one triangle number per beat.
// The result channel (o_res_valid / i_res_ready) returns one beat per input beat,
// in order, holding the three vertex indices and valid_res. Triangle numbers past
// the patch total, or an exponent of zero, give valid_res low and zero vertices.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the subdivision
// exponent; it is always ready and should only be written while no beat is in flight.
// Exponents above MAX_EXPONENT are clamped to it.
// An accepted beat lands in the input register, and its indices are then loaded into
// the result register that drives the outputs once that register is free.
// Throughput is one beat per cycle while the receiver does not stall; the index math
// is shift-and-add logic that sits entirely between those two registers.
// Reset empties both registers and sets the exponent to 1.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; ready drops only once both are full.

`default_nettype none
`include "terrain_grid_skirt_index_gen_core_macros.svh"

module terrain_grid_skirt_index_gen_core #(
    parameter int MAX_EXPONENT = tgsi_pkg::MAX_EXPONENT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration write channel.
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tgsi_pkg::EXP_W-1:0] i_cfg_subdivision_exponent,
    // Triangle number channel.
    input  wire logic                       i_tri_valid,
    output logic                            o_tri_ready,
    input  wire logic [tgsi_pkg::TRI_W-1:0] i_triangle_number,
    // Vertex index result channel.
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic [tgsi_pkg::VTX_W-1:0]      o_vertex_a,
    output logic [tgsi_pkg::VTX_W-1:0]      o_vertex_b,
    output logic [tgsi_pkg::VTX_W-1:0]      o_vertex_c,
    output logic                            o_valid_res
);

    logic [tgsi_pkg::EXP_W-1:0] r_cfg_exp;
    logic [tgsi_pkg::EXP_W-1:0] n_cfg_exp;
    logic                       r_s1_valid;
    logic                       n_s1_valid;
    logic [tgsi_pkg::TRI_W-1:0] r_s1_tri;
    logic                       r_o_valid;
    logic                       n_o_valid;
    tgsi_pkg::t_tri_res         r_o_res;
    tgsi_pkg::t_tri_res         w_res;
    logic                       w_s2_ready;
    logic                       w_in_fire;
    logic                       w_s1_move;

    // The result register frees up when empty or when its beat is taken this cycle;
    // the input register can then pass its beat on and take a new one.
    assign w_s2_ready  = !r_o_valid || i_res_ready;
    assign o_tri_ready = !r_s1_valid || w_s2_ready;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_tri_valid && o_tri_ready;
    assign w_s1_move   = r_s1_valid && w_s2_ready;

    tgsi_index_calc #(
        .MAX_EXPONENT(MAX_EXPONENT)
    ) u_calc (
        .i_exponent       (r_cfg_exp),
        .i_triangle_number(r_s1_tri),
        .o_res            (w_res)
    );

    always_comb begin
        n_cfg_exp  = r_cfg_exp;
        n_s1_valid = r_s1_valid;
        n_o_valid  = r_o_valid;
        if (i_cfg_valid && o_cfg_ready) begin
            n_cfg_exp = i_cfg_subdivision_exponent;
        end
        if (o_tri_ready) begin
            n_s1_valid = i_tri_valid;
        end
        if (w_s2_ready) begin
            n_o_valid = r_s1_valid;
        end
    end

    // Control state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_exp  <= tgsi_pkg::EXP_RESET;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_cfg_exp  <= n_cfg_exp;
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers load only when a beat moves into them.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_tri <= i_triangle_number;
        end
        if (w_s1_move) begin
            r_o_res <= w_res;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_vertex_a  = r_o_res.vertex_a;
    assign o_vertex_b  = r_o_res.vertex_b;
    assign o_vertex_c  = r_o_res.vertex_c;
    assign o_valid_res = r_o_res.valid_res;

    `TGSI_ASSERT_NEXT(a_in_lands, w_in_fire, r_s1_valid, "accepted beat missing from input register")
    `TGSI_ASSERT_NEXT(a_s1_moves, w_s1_move, r_o_valid, "beat lost between input and result register")
    `TGSI_ASSERT_NEXT(a_s1_holds, r_s1_valid && !w_s2_ready, r_s1_valid && $stable(r_s1_tri), "stalled input register dropped its beat")
    `TGSI_ASSERT_NOW(a_invalid_zero, r_o_valid && !r_o_res.valid_res, (r_o_res.vertex_a == '0) && (r_o_res.vertex_b == '0) && (r_o_res.vertex_c == '0), "invalid triangle with nonzero vertices")

endmodule

`default_nettype wire

// ===== dv/tb_terrain_grid_skirt_index_gen_core.sv =====
// Self-checking testbench for terrain_grid_skirt_index_gen_core: triangle numbers in, vertex
// indices out, checked beat by beat against a predictor kept inside this file.
// Depends on tgsi_pkg and the core RTL only.
module tb_terrain_grid_skirt_index_gen_core;
    import tgsi_pkg::*;

    localparam int SKIRT_SIDES = 4;
    localparam int PHASE_COUNT = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [EXP_W-1:0] cfg_exponent = '0;
    logic             tri_valid = 1'b0;
    logic [TRI_W-1:0] tri_number = '0;
    logic             res_ready = 1'b0;
    wire              cfg_ready;
    wire              tri_ready;
    wire              res_valid;
    wire [VTX_W-1:0]  vertex_a;
    wire [VTX_W-1:0]  vertex_b;
    wire [VTX_W-1:0]  vertex_c;
    wire              valid_res;

    // Stimulus and scoreboard state.
    logic [TRI_W-1:0] pending_triangles[$];
    t_tri_res         expected_vertices[$];
    logic [EXP_W-1:0] exponent_shadow = EXP_RESET;
    int unsigned      queued_count = 0;
    int unsigned      accepted_count = 0;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    int unsigned      gap_left = 0;
    int unsigned      stall_phase = 0;
    int unsigned      stall_mode = 0;

    terrain_grid_skirt_index_gen_core dut (
        .i_clk                      (clk),
        .i_rst_n                    (rst_n),
        .i_cfg_valid                (cfg_valid),
        .o_cfg_ready                (cfg_ready),
        .i_cfg_subdivision_exponent (cfg_exponent),
        .i_tri_valid                (tri_valid),
        .o_tri_ready                (tri_ready),
        .i_triangle_number          (tri_number),
        .o_res_valid                (res_valid),
        .i_res_ready                (res_ready),
        .o_vertex_a                 (vertex_a),
        .o_vertex_b                 (vertex_b),
        .o_vertex_c                 (vertex_c),
        .o_valid_res                (valid_res)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Works out the three vertex indices of one triangle for a given exponent. Grid
    // triangles come two per cell in row order; the skirt follows, side by side.
    function automatic t_tri_res predict_triangle(input logic [EXP_W-1:0] exponent,
                                                  input logic [TRI_W-1:0] tri_num);
        t_tri_res    res;
        int unsigned k, m, n, grid, total, t, cell_num, row, col, base;
        int unsigned s, step, e0, e1, s0, s1, va, vb, vc;
        logic [1:0]  side;
        res = '0;
        k = exponent;
        if (k > MAX_EXPONENT_DEF) begin
            k = MAX_EXPONENT_DEF;
        end
        // An exponent of zero describes an empty patch, so nothing is valid.
        if (k == 0) begin
            return res;
        end
        t = tri_num;
        m = 1 << k;
        n = m + 1;
        grid = 2 * m * m;
        total = grid + 2 * m * SKIRT_SIDES;
        if (t >= total) begin
            return res;
        end
        if (t < grid) begin
            cell_num = t >> 1;
            row = cell_num >> k;
            col = cell_num & (m - 1);
            base = row * n + col;
            va = base;
            if (tri_num[0] == 1'b0) begin
                vb = base + 1;
                vc = base + n + 1;
            end else begin
                vb = base + n + 1;
                vc = base + n;
            end
        end else begin
            s = t - grid;
            side = 2'(s >> (k + 1));
            step = (s >> 1) & (m - 1);
            s0 = n * n + m * side + step;
            s1 = s0 + 1;
            case (side)
                SIDE_TOP: begin
                    e0 = step;
                    e1 = step + 1;
                end
                SIDE_RIGHT: begin
                    e0 = n * step + m;
                    e1 = n * (step + 1) + m;
                end
                SIDE_BOTTOM: begin
                    e0 = n * m + m - step;
                    e1 = e0 - 1;
                end
                default: begin
                    e0 = n * (m - step);
                    e1 = n * (m - step - 1);
                    // The skirt closes on itself: the final step wraps to its first vertex.
                    if (step == m - 1) begin
                        s1 = n * n;
                    end
                end
            endcase
            if ((s & 1) == 0) begin
                va = e0;
                vb = s0;
                vc = e1;
            end else begin
                va = e1;
                vb = s0;
                vc = s1;
            end
        end
        res.vertex_a = VTX_W'(va);
        res.vertex_b = VTX_W'(vb);
        res.vertex_c = VTX_W'(vc);
        res.valid_res = 1'b1;
        return res;
    endfunction

    // Random triangle number, weighted toward the grid and skirt of the current patch.
    function automatic logic [TRI_W-1:0] pick_triangle(input logic [EXP_W-1:0] exponent);
        int unsigned m, grid, total, roll;
        roll = $urandom_range(0, 99);
        if (exponent == 0 || roll >= 93) begin
            return TRI_W'($urandom);
        end
        m = 1 << exponent;
        grid = 2 * m * m;
        total = grid + 2 * m * SKIRT_SIDES;
        if (roll < 45) begin
            return TRI_W'($urandom_range(0, grid - 1));
        end else if (roll < 80) begin
            return TRI_W'($urandom_range(grid, total - 1));
        end else if (roll < 85) begin
            return TRI_W'(total - 1 - $urandom_range(0, 3));
        end
        return TRI_W'($urandom_range(total, (1 << TRI_W) - 1));
    endfunction

    task automatic push_triangle(input logic [TRI_W-1:0] tri_num);
        pending_triangles.push_back(tri_num);
        queued_count++;
    endtask

    // Sampled on the falling edge so the check never races the clocked blocks.
    task automatic wait_until_drained();
        do begin
            @(negedge clk);
        end while (!(accepted_count == queued_count && expected_vertices.size() == 0));
    endtask

    task automatic write_exponent(input logic [EXP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_exponent <= value;
        do begin
            @(posedge clk);
        end while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [VTX_W-1:0] want,
                               input logic [VTX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // The exponent copy follows each configuration beat.
    always @(posedge clk) begin
        if (!rst_n) begin
            exponent_shadow <= EXP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            exponent_shadow <= cfg_exponent;
        end
    end

    // Triangle driver: records the expectation for each accepted beat, then presents the
    // next pending number in bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            tri_valid <= 1'b0;
        end else begin
            if (tri_valid && tri_ready) begin
                expected_vertices.push_back(predict_triangle(exponent_shadow, tri_number));
                accepted_count++;
            end
            if (!tri_valid || tri_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tri_valid <= 1'b0;
                end else if (pending_triangles.size() > 0) begin
                    tri_valid <= 1'b1;
                    tri_number <= pending_triangles.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    tri_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. The ready pattern is redrawn at random, periodically, from always ready,
    // random stalls, and a sparse periodic ready.
    always @(posedge clk) begin
        t_tri_res want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0d %0d %0d %0d",
                             $time, vertex_a, vertex_b, vertex_c, valid_res);
                    error_count++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("vertex_a", want.vertex_a, vertex_a);
                    check_field("vertex_b", want.vertex_b, vertex_b);
                    check_field("vertex_c", want.vertex_c, vertex_c);
                    check_field("valid_res", VTX_W'(want.valid_res), VTX_W'(valid_res));
                end
            end
            stall_phase++;
            if (stall_phase % 256 == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 9) < 7);
                default: res_ready <= (stall_phase % 4 == 3);
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_vertices.size());
            $display("terrain_grid_skirt_index_gen_core verification failed");
            $finish;
        end
    end

    initial begin
        logic [EXP_W-1:0] phase_exponents[PHASE_COUNT];
        logic [EXP_W-1:0] swap;
        int unsigned      j;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset exponent: grid corners, the first and last beat of
        // every skirt side (the last one wraps), and numbers past the total.
        push_triangle(0);
        push_triangle(1);
        push_triangle(7);
        push_triangle(8);
        push_triangle(9);
        push_triangle(11);
        push_triangle(12);
        push_triangle(15);
        push_triangle(16);
        push_triangle(19);
        push_triangle(20);
        push_triangle(22);
        push_triangle(23);
        push_triangle(24);
        push_triangle(16'hFFFF);
        wait_until_drained();

        // Largest patch: the grid boundary, the wrapping skirt beat and the total itself.
        write_exponent(3'd7);
        push_triangle(0);
        push_triangle(32767);
        push_triangle(32768);
        push_triangle(33790);
        push_triangle(33791);
        push_triangle(33792);
        push_triangle(16'hFFFF);
        wait_until_drained();

        // Empty patch: every number is invalid.
        write_exponent(3'd0);
        push_triangle(0);
        push_triangle(16'hFFFF);
        wait_until_drained();

        // Random phases: every exponent once in shuffled order, then a couple more.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            phase_exponents[p] = (p < 8) ? EXP_W'(p) : EXP_W'($urandom_range(1, 7));
        end
        for (int p = 7; p > 0; p--) begin
            j = $urandom_range(0, p);
            swap = phase_exponents[p];
            phase_exponents[p] = phase_exponents[j];
            phase_exponents[j] = swap;
        end
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_exponent(phase_exponents[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // One mid-phase hold-off lets the pipeline run completely dry.
                if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
                    wait_until_drained();
                end
                push_triangle(pick_triangle(phase_exponents[p]));
            end
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("terrain_grid_skirt_index_gen_core verification clean");
        end else begin
            $display("terrain_grid_skirt_index_gen_core verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tgsi_pkg.sv
rtl/tgsi_index_calc.sv
rtl/terrain_grid_skirt_index_gen_core.sv
dv/tb_terrain_grid_skirt_index_gen_core.sv
